// ===== rtl/core/packet_buffer_manager_top_defines.svh =====
// ----------------------------------------------------------------------------
// Packet buffer manager assertion macros
// Shared concurrent assertion forms for the buffer manager RTL.
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_MANAGER_TOP_DEFINES_SVH
`define PACKET_BUFFER_MANAGER_TOP_DEFINES_SVH

// Check that an expression holds on every clock edge out of reset.
`define PBM_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define PBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet buffer manager package
// Opcodes, field widths and the ring request bundle.
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int IDX_W     = 8;  // buffer index field
    localparam int CNT_OUT_W = 9;  // reported count fields
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_AUD_ENQ = 3'd2,
        OP_AUD_DEQ = 3'd3,
        OP_VID_ENQ = 3'd4,
        OP_VID_DEQ = 3'd5
    } op_t;

    // One request to a ring: at most one of push and pop is set.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] wdata;
    } ring_req_t;

endpackage

// ===== rtl/core/pbm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module pbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pbm_ring.sv =====
// ----------------------------------------------------------------------------
// Buffer manager ring
// Head, tail and fill count around one RAM; push at tail, pop at head.
// ----------------------------------------------------------------------------
`include "packet_buffer_manager_top_defines.svh"

module pbm_ring #(
    parameter int NUM_BUFFERS = 256,
    parameter bit INIT_FULL   = 1'b0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pbm_pkg::ring_req_t               req,
    output logic                             ok,
    output logic [$clog2(NUM_BUFFERS+1)-1:0] fill,
    output logic [pbm_pkg::IDX_W-1:0]        rdata
);

    import pbm_pkg::*;

    localparam int PTR_W = $clog2(NUM_BUFFERS);
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_BUFFERS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BUFFERS);
    localparam logic [CNT_W-1:0] RST_CNT  = INIT_FULL ? FULL_CNT : '0;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             full, empty, do_push, do_pop;
    logic [IDX_W-1:0] ram_rdata;

    assign full    = (fill_reg == FULL_CNT);
    assign empty   = (fill_reg == '0);
    assign do_push = req.push && !full;
    assign do_pop  = req.pop && !empty;
    assign ok      = do_push || do_pop;
    assign fill    = fill_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_push) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (do_pop) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= RST_CNT;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    pbm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_BUFFERS)
    ) u_ram (
        .aclk  (aclk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (req.wdata),
        .re    (do_pop),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    generate
        if (INIT_FULL) begin : g_init
            // Writes land at the tail from slot 0 upward, so a slot below the tail, or
            // any slot once the tail has wrapped, holds written data; the rest still
            // hold their own index.
            logic             lap_reg;
            logic             init_hit_reg;
            logic [IDX_W-1:0] init_val_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    lap_reg <= 1'b0;
                end else if (do_push && tail_reg == LAST_PTR) begin
                    lap_reg <= 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (do_pop) begin
                    init_hit_reg <= !(lap_reg || head_reg < tail_reg);
                    init_val_reg <= IDX_W'(head_reg);
                end
            end

            assign rdata = init_hit_reg ? init_val_reg : ram_rdata;
        end else begin : g_plain
            assign rdata = ram_rdata;
        end
    endgenerate

    `PBM_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= FULL_CNT, "ring fill overflow")
    `PBM_ASSERT_ALWAYS(a_ptr_fill, aclk, aresetn,
        (head_reg == tail_reg) == (fill_reg == '0 || fill_reg == FULL_CNT),
        "ring pointers disagree with fill")
    `PBM_ASSERT_NEXT(a_push_cnt, aclk, aresetn, aresetn && do_push,
        fill_reg == $past(fill_reg) + 1'b1, "push did not raise fill")
    `PBM_ASSERT_NEXT(a_pop_cnt, aclk, aresetn, aresetn && do_pop,
        fill_reg == $past(fill_reg) - 1'b1, "pop did not lower fill")

endmodule

// ===== rtl/core/packet_buffer_manager_top.sv =====
// ----------------------------------------------------------------------------
// Packet buffer manager top level
// Free list of buffer indices plus audio and video index queues.
// ----------------------------------------------------------------------------
// One operation per word on the slave side, one result word per operation on
// the master side. The block takes a new operation in every cycle as long as
// results drain; each result passes through stage one, where the ring RAM
// reads at the accepting edge, and then the result register, which loads once
// it is free.
// The free list comes out of reset full, holding indices 0..NUM_BUFFERS-1 in
// order, with no clearing pass: slots not yet rewritten answer with their own
// index. A push to a full ring or a pop from an empty ring changes nothing and
// returns done_res low with out_index zero; unused opcodes do the same. Counts
// are reported after the operation, truncated to nine bits.
module packet_buffer_manager_top #(
    parameter int NUM_BUFFERS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side: one operation per word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] buffer_index
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // master side: one result per word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_index, [16:8] free_count,
                                   // [25:17] audio_count, [34:26] video_count, rest 0
    output logic [0:0]  m_tuser    // [0] done_res
);

    import pbm_pkg::*;

    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

    logic      accept, out_free, st1_adv;
    op_t       in_op;
    ring_req_t free_req, aud_req, vid_req;
    logic      free_ok, aud_ok, vid_ok;

    logic [CNT_W-1:0] free_fill, aud_fill, vid_fill;
    logic [IDX_W-1:0] free_rdata, aud_rdata, vid_rdata;

    // stage one: operation issued to a ring, read data on its way
    logic st1_valid_reg, st1_valid_next;
    op_t  st1_op_reg;
    logic st1_done_reg;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic                 m_done_reg;
    logic [IDX_W-1:0]     m_index_reg, m_index_next;
    logic [CNT_OUT_W-1:0] m_free_reg, m_aud_reg, m_vid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_tready = !st1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);

    // Steer the accepted word to its ring.
    always_comb begin
        free_req = '{push: 1'b0, pop: 1'b0, wdata: s_tdata};
        aud_req  = '{push: 1'b0, pop: 1'b0, wdata: s_tdata};
        vid_req  = '{push: 1'b0, pop: 1'b0, wdata: s_tdata};
        if (accept) begin
            unique case (in_op)
                OP_ALLOC:   free_req.pop  = 1'b1;
                OP_RELEASE: free_req.push = 1'b1;
                OP_AUD_ENQ: aud_req.push  = 1'b1;
                OP_AUD_DEQ: aud_req.pop   = 1'b1;
                OP_VID_ENQ: vid_req.push  = 1'b1;
                OP_VID_DEQ: vid_req.pop   = 1'b1;
                default: ;
            endcase
        end
    end

    pbm_ring #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .INIT_FULL   (1'b1)
    ) u_free (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (free_req),
        .ok      (free_ok),
        .fill    (free_fill),
        .rdata   (free_rdata)
    );

    pbm_ring #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .INIT_FULL   (1'b0)
    ) u_audio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (aud_req),
        .ok      (aud_ok),
        .fill    (aud_fill),
        .rdata   (aud_rdata)
    );

    pbm_ring #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .INIT_FULL   (1'b0)
    ) u_video (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (vid_req),
        .ok      (vid_ok),
        .fill    (vid_fill),
        .rdata   (vid_rdata)
    );

    // Hold stage one until the result register frees up.
    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    // Only one ring sees a request, so the OR picks its outcome.
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_op_reg   <= in_op;
            st1_done_reg <= free_ok || aud_ok || vid_ok;
        end
    end

    // Popped index comes from the ring that was read; zero when nothing popped.
    always_comb begin
        m_index_next = '0;
        if (st1_done_reg) begin
            unique case (st1_op_reg)
                OP_ALLOC:   m_index_next = free_rdata;
                OP_AUD_DEQ: m_index_next = aud_rdata;
                OP_VID_DEQ: m_index_next = vid_rdata;
                default:    m_index_next = '0;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (st1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Fill registers already reflect the stage-one operation here.
    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_done_reg  <= st1_done_reg;
            m_index_reg <= m_index_next;
            m_free_reg  <= CNT_OUT_W'(free_fill);
            m_aud_reg   <= CNT_OUT_W'(aud_fill);
            m_vid_reg   <= CNT_OUT_W'(vid_fill);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_done_reg;
    assign m_tdata  = {5'b0, m_vid_reg, m_aud_reg, m_free_reg, m_index_reg};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet buffer manager testbench
// Drives allocate, release, enqueue and dequeue words into the buffer manager.
// A software copy of the free list and the two class queues predicts every
// result word. Random gaps and stalls fall on both sides, and the run
// deliberately fills and empties each ring.
// ----------------------------------------------------------------------------
module testbench;
    import pbm_pkg::*;

    localparam int NUM_BUFFERS = 256;
    localparam int CYCLE_LIMIT = 600000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 10;     // idle wait after the last result, in cycles
    localparam int LONG_HOLD = 500;       // long receiver hold-off, in cycles
    localparam int HOLD_AT_A = 600;
    localparam int HOLD_AT_B = 2400;

    // Opcodes the block does not define; they must come back refused.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef enum int {
        RING_FREE  = 0,
        RING_AUDIO = 1,
        RING_VIDEO = 2
    } ring_id_t;

    typedef struct {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] buffer_index;
    } op_word_t;

    typedef struct {
        logic                 done;
        logic [IDX_W-1:0]     index;
        logic [CNT_OUT_W-1:0] free_cnt;
        logic [CNT_OUT_W-1:0] audio_cnt;
        logic [CNT_OUT_W-1:0] video_cnt;
    } buf_result_t;

    // ------------------------------------------------------------------------
    // Block ports, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;   // [7:0] buffer_index
    logic [2:0]       s_tuser = '0;   // [2:0] opcode
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [39:0]      m_tdata;        // [7:0] out_index, [16:8] free_count,
                                      // [25:17] audio_count, [34:26] video_count
    logic [0:0]       m_tuser;        // [0] done_res

    packet_buffer_manager_top #(
        .NUM_BUFFERS(NUM_BUFFERS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 2 ns period: one delay high, one low.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the three rings
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] ring_slot [3][NUM_BUFFERS];
    int               ring_head [3];
    int               ring_tail [3];
    int               ring_fill [3];

    // Bookkeeping for the summary and the checks.
    buf_result_t awaited_results [$];
    op_word_t    op_backlog [$];
    int          total_ops = 0;
    int          words_taken = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          ops_performed = 0;
    int          push_refused = 0;
    int          pop_refused = 0;
    int          unused_ops = 0;
    int          peak_fill [3];
    int          holds_done = 0;

    // Push onto a ring; refuse when it is full.
    function automatic bit ring_push(ring_id_t r, logic [IDX_W-1:0] value);
        if (ring_fill[r] >= NUM_BUFFERS) begin
            push_refused++;
            return 1'b0;
        end
        ring_slot[r][ring_tail[r]] = value;
        ring_tail[r] = (ring_tail[r] + 1) % NUM_BUFFERS;
        ring_fill[r]++;
        if (ring_fill[r] > peak_fill[r]) begin
            peak_fill[r] = ring_fill[r];
        end
        return 1'b1;
    endfunction

    // Pop from a ring; refuse when it is empty.
    function automatic bit ring_pop(ring_id_t r, output logic [IDX_W-1:0] value);
        value = '0;
        if (ring_fill[r] == 0) begin
            pop_refused++;
            return 1'b0;
        end
        value = ring_slot[r][ring_head[r]];
        ring_head[r] = (ring_head[r] + 1) % NUM_BUFFERS;
        ring_fill[r]--;
        return 1'b1;
    endfunction

    // Apply one accepted operation word to the shadow rings and return the
    // result word the block must produce for it.
    function automatic buf_result_t apply_buffer_op(logic [OP_W-1:0] opcode,
                                                    logic [IDX_W-1:0] idx);
        buf_result_t      res;
        logic [IDX_W-1:0] taken;
        bit               done;
        taken = '0;
        done = 1'b0;
        case (opcode)
            OP_ALLOC:   done = ring_pop(RING_FREE, taken);
            OP_RELEASE: done = ring_push(RING_FREE, idx);
            OP_AUD_ENQ: done = ring_push(RING_AUDIO, idx);
            OP_AUD_DEQ: done = ring_pop(RING_AUDIO, taken);
            OP_VID_ENQ: done = ring_push(RING_VIDEO, idx);
            OP_VID_DEQ: done = ring_pop(RING_VIDEO, taken);
            default:    unused_ops++;
        endcase
        if (done) begin
            ops_performed++;
        end
        res.done      = done;
        res.index     = done ? taken : '0;
        res.free_cnt  = CNT_OUT_W'(ring_fill[RING_FREE]);
        res.audio_cnt = CNT_OUT_W'(ring_fill[RING_AUDIO]);
        res.video_cnt = CNT_OUT_W'(ring_fill[RING_VIDEO]);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_op(logic [OP_W-1:0] opcode, logic [IDX_W-1:0] idx);
        op_word_t w;
        w.opcode = opcode;
        w.buffer_index = idx;
        op_backlog.push_back(w);
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Index mostly uniform, with the two extremes favored a little.
    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return IDX_W'($urandom_range(0, 255));
    endfunction

    // Queue a run of random operations with the given weights, in opcode
    // order, the last weight covering the unused opcodes.
    function automatic void queue_segment(int count, int w_alloc, int w_rel,
                                          int w_aenq, int w_adeq, int w_venq,
                                          int w_vdeq, int w_bad);
        int weights [7];
        int total;
        int r;
        int k;
        logic [OP_W-1:0] opcode;
        weights = '{w_alloc, w_rel, w_aenq, w_adeq, w_venq, w_vdeq, w_bad};
        total = w_alloc + w_rel + w_aenq + w_adeq + w_venq + w_vdeq + w_bad;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, total - 1);
            k = 0;
            while (r >= weights[k]) begin
                r -= weights[k];
                k++;
            end
            if (k == 6) begin
                opcode = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
            end else begin
                opcode = OP_W'(k);
            end
            queue_op(opcode, pick_index());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer backlog words, hold while stalled, insert random gaps
    // ------------------------------------------------------------------------
    int       tx_gap = 0;
    op_word_t tx_word;

    function automatic int pick_sender_gap();
        // Keep every third block of 128 words free of gaps.
        if ((words_taken / 128) % 3 == 1) begin
            return 0;
        end
        return ($urandom_range(0, 99) < 35) ? idle_len() : 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap = 0;
        end else begin
            // Predict the word the block takes at this edge.
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_buffer_op(s_tuser, s_tdata));
                words_taken++;
                tx_gap = pick_sender_gap();
            end
            // Hold a stalled word; otherwise idle or advance to the next one.
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap--;
                end else if (op_backlog.size() != 0) begin
                    tx_word = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_word.buffer_index;
                    s_tuser  <= tx_word.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm windows, and two long hold-offs that let
    // the result path back up into the input
    // ------------------------------------------------------------------------
    int rx_cycle = 0;
    int rx_stall = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            rx_stall = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_AT_A || rx_cycle == HOLD_AT_B) begin
                rx_stall = LONG_HOLD;
                holds_done++;
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else if ((rx_cycle / 300) % 4 == 0) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                rx_stall = idle_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------------
    buf_result_t rx_want;

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result word %0d arrived with no operation pending", results_seen);
                fail_count++;
            end else begin
                rx_want = awaited_results.pop_front();
                check_field("done_res", rx_want.done, m_tuser[0]);
                check_field("out_index", rx_want.index, m_tdata[7:0]);
                check_field("free_count", rx_want.free_cnt, m_tdata[16:8]);
                check_field("audio_count", rx_want.audio_cnt, m_tdata[25:17]);
                check_field("video_count", rx_want.video_cnt, m_tdata[34:26]);
            end
        end
    end

    // Watchdog: give up if the run stalls.
    int watchdog = 0;

    always @(posedge aclk) begin
        watchdog++;
        if (watchdog >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: load the shadow rings, fill the backlog, reset, drain
    // ------------------------------------------------------------------------
    initial begin
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                ring_slot[r][i] = (r == RING_FREE) ? IDX_W'(i) : '0;
            end
            ring_head[r] = 0;
            ring_tail[r] = 0;
            ring_fill[r] = (r == RING_FREE) ? NUM_BUFFERS : 0;
            peak_fill[r] = ring_fill[r];
        end

        // Directed: refusals on a full free list and empty queues, unused
        // opcodes, extreme indices, and a repeated foreign release.
        queue_op(OP_RELEASE, 8'h00);
        queue_op(OP_AUD_DEQ, 8'hFF);
        queue_op(OP_VID_DEQ, 8'h00);
        queue_op(OP_UNUSED_LO, 8'hFF);
        queue_op(OP_UNUSED_HI, 8'h00);
        queue_op(OP_ALLOC, 8'hFF);
        queue_op(OP_ALLOC, 8'h00);
        queue_op(OP_AUD_ENQ, 8'h00);
        queue_op(OP_AUD_ENQ, 8'hFF);
        queue_op(OP_VID_ENQ, 8'hAA);
        queue_op(OP_VID_ENQ, 8'h55);
        queue_op(OP_AUD_DEQ, 8'h00);
        queue_op(OP_AUD_DEQ, 8'h00);
        queue_op(OP_AUD_DEQ, 8'h00);
        queue_op(OP_VID_DEQ, 8'hFF);
        queue_op(OP_VID_DEQ, 8'hFF);
        queue_op(OP_VID_DEQ, 8'hFF);
        queue_op(OP_RELEASE, 8'hFF);
        queue_op(OP_RELEASE, 8'hFF);
        queue_op(OP_RELEASE, 8'h00);
        queue_op(OP_ALLOC, 8'h00);

        // Random: fill the audio queue, then the video queue, then drain the
        // free list past empty, then mix everything.
        queue_segment(300, 1, 1, 92, 2, 2, 1, 1);
        queue_segment(300, 1, 1, 2, 1, 92, 2, 1);
        queue_segment(300, 92, 2, 1, 2, 1, 1, 1);
        queue_segment(200, 15, 15, 15, 15, 15, 15, 10);
        total_ops = op_backlog.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_taken != total_ops) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operations: %0d performed, %0d pushes to full,",
                 total_ops, ops_performed, push_refused);
        $display("  %0d pops from empty, %0d unused opcodes", pop_refused, unused_ops);
        $display("peak fill free/audio/video %0d/%0d/%0d, %0d long receiver hold-offs, %0d errors",
                 peak_fill[RING_FREE], peak_fill[RING_AUDIO], peak_fill[RING_VIDEO],
                 holds_done, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pbm_pkg.sv
rtl/core/pbm_ram.sv
rtl/core/pbm_ring.sv
rtl/core/packet_buffer_manager_top.sv
tb/sv/testbench.sv
